// ===== rtl/irl_pkg.sv =====
// ----------------------------------------------------------------------------
// irl_pkg: shared types and constants of the innermost rectangle locator
// Holds the table size, field widths and the structs that pass between the
// top level and the row of area cells.
// ----------------------------------------------------------------------------
package irl_pkg;

	localparam int MAX_AREAS    = 64;
	localparam int IDX_W        = $clog2(MAX_AREAS);
	localparam int CNT_W        = 7;
	localparam int PATH_ID_BITS = 16;
	localparam int COORD_W      = 32;
	localparam int DBL_W        = COORD_W + 2;
	localparam int SURF_W       = 2 * COORD_W;

	// Straightened area entry broadcast to the cells on a write beat.
	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] depth;
		logic [PATH_ID_BITS-1:0]   path;
	} area_t;

	// Query held stable while it walks the row.
	typedef struct packed {
		logic signed [DBL_W-1:0]  cx2;
		logic signed [DBL_W-1:0]  cy2;
		logic [PATH_ID_BITS-1:0]  cur;
	} query_t;

	// Best candidate so far, handed from cell to cell.
	typedef struct packed {
		logic                      found;
		logic                      claimed;
		logic [PATH_ID_BITS-1:0]   path;
		logic [SURF_W-1:0]         surf;
		logic signed [COORD_W-1:0] depth;
	} best_t;

endpackage

// ===== rtl/irl_cell.sv =====
// ----------------------------------------------------------------------------
// irl_cell: one table entry of the innermost rectangle locator
// Stores one area, tests the query centre against it and merges its own
// candidate into the best result coming from the previous cell.
// ----------------------------------------------------------------------------
module irl_cell import irl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  area_t  wr_area,
	input  logic   in_use,
	input  query_t query,
	input  best_t  best_in,
	output best_t  best_out
);

	area_t                   entry_q;
	logic                    hit_q;
	logic                    claim_q;
	logic [SURF_W-1:0]       surf_q;

	logic                    named;
	logic                    hit;
	logic signed [DBL_W-1:0] l2, r2, t2, b2;
	logic signed [COORD_W:0] wdiff, hdiff;
	logic                    take;
	best_t                   best_nx;

	// Entry storage, written on an area write beat aimed at this cell.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_area;
		end
	end

	// Containment test against doubled edges; edges count as inside.
	always_comb begin
		named = in_use && (entry_q.path != '0);
		l2    = {{(DBL_W-COORD_W){entry_q.left[COORD_W-1]}}, entry_q.left} <<< 1;
		r2    = {{(DBL_W-COORD_W){entry_q.right[COORD_W-1]}}, entry_q.right} <<< 1;
		t2    = {{(DBL_W-COORD_W){entry_q.top[COORD_W-1]}}, entry_q.top} <<< 1;
		b2    = {{(DBL_W-COORD_W){entry_q.bottom[COORD_W-1]}}, entry_q.bottom} <<< 1;
		wdiff = {entry_q.right[COORD_W-1], entry_q.right}
			- {entry_q.left[COORD_W-1], entry_q.left};
		hdiff = {entry_q.bottom[COORD_W-1], entry_q.bottom}
			- {entry_q.top[COORD_W-1], entry_q.top};
		hit   = named && (entry_q.right > entry_q.left) && (entry_q.bottom > entry_q.top)
			&& (query.cx2 >= l2) && (query.cx2 <= r2)
			&& (query.cy2 >= t2) && (query.cy2 <= b2);
	end

	// Candidate stage: hit flag, path claim and the area product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			claim_q <= 1'b0;
		end else begin
			hit_q   <= hit;
			claim_q <= named && (entry_q.path == query.cur);
		end
	end

	always_ff @(posedge clk) begin
		surf_q <= SURF_W'(wdiff[COORD_W-1:0]) * SURF_W'(hdiff[COORD_W-1:0]);
	end

	// Merge stage: a smaller area wins, then a strictly larger depth.
	always_comb begin
		take = hit_q && (!best_in.found || (surf_q < best_in.surf)
			|| ((surf_q == best_in.surf) && (entry_q.depth > best_in.depth)));
		best_nx         = best_in;
		best_nx.claimed = best_in.claimed | claim_q;
		if (take) begin
			best_nx.found = 1'b1;
			best_nx.path  = entry_q.path;
			best_nx.surf  = surf_q;
			best_nx.depth = entry_q.depth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_out <= '0;
		end else begin
			best_out <= best_nx;
		end
	end

endmodule

// ===== rtl/innermost_rectangle_locator.sv =====
// ----------------------------------------------------------------------------
// innermost_rectangle_locator: finds the smallest named area around a point
// Top level with the stream ports, the query sequencer and the row of cells.
// ----------------------------------------------------------------------------
// An area write beat returns nothing. For a query beat the query is first loaded
// into a register, every cell then registers its candidate, and the best result
// ripples from there through the row of cells one cell per cycle. One query is in
// flight at a time; the next beat is taken as soon as the result sits in the
// output register, or once a query ends with no result to emit.
module innermost_rectangle_locator import irl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_data,       // area_count
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// area_index[5:0], corner_ax[37:6], corner_ay[69:38], corner_bx[101:70],
	// corner_by[133:102], depth_z[165:134], path_id[181:166],
	// item_id[197:182], item_path[213:198], zero fill[215:214]
	input  logic [215:0] s_axis_tdata,
	input  logic         s_axis_tuser,   // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata    // changed_item[15:0], new_path[31:16]
);

	localparam int RUN_CYCLES = MAX_AREAS;
	localparam int RUN_W      = $clog2(RUN_CYCLES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t               state_q;
	logic [RUN_W-1:0]     run_cnt_q;
	logic [CNT_W-1:0]     area_count_q;
	query_t               query_q;
	logic [15:0]          item_q;
	logic                 out_valid_q;
	logic [31:0]          out_data_q;

	logic [IDX_W-1:0]          in_index;
	logic signed [COORD_W-1:0] ax, ay, bx, by, dz;
	logic [15:0]               in_path, in_item, in_cur;
	logic                      accept;
	logic                      wr_beat;
	area_t                     wr_area;
	best_t                     chain [MAX_AREAS+1];
	logic                      emit;
	logic [PATH_ID_BITS-1:0]   emit_path;
	best_t                     fin;
	logic                      load_out;

	// Field unpacking.
	assign in_index = s_axis_tdata[5:0];
	assign ax       = s_axis_tdata[37:6];
	assign ay       = s_axis_tdata[69:38];
	assign bx       = s_axis_tdata[101:70];
	assign by       = s_axis_tdata[133:102];
	assign dz       = s_axis_tdata[165:134];
	assign in_path  = s_axis_tdata[181:166];
	assign in_item  = s_axis_tdata[197:182];
	assign in_cur   = s_axis_tdata[213:198];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign wr_beat       = accept && !s_axis_tuser;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Straighten the corners of a written area.
	always_comb begin
		wr_area.left   = (ax < bx) ? ax : bx;
		wr_area.right  = (ax < bx) ? bx : ax;
		wr_area.top    = (ay < by) ? ay : by;
		wr_area.bottom = (ay < by) ? by : ay;
		wr_area.depth  = dz;
		wr_area.path   = PATH_ID_BITS'(in_path);
	end

	// Row of cells; each hands its best candidate to the next.
	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_AREAS; i++) begin : g_cell
		irl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_beat && (in_index == IDX_W'(i))),
			.wr_area  (wr_area),
			.in_use   (area_count_q > CNT_W'(i)),
			.query    (query_q),
			.best_in  (chain[i]),
			.best_out (chain[i+1])
		);
	end

	// Result decision from the last cell.
	always_comb begin
		fin       = chain[MAX_AREAS];
		emit      = 1'b0;
		emit_path = '0;
		if (fin.found) begin
			emit      = (fin.path != query_q.cur);
			emit_path = fin.path;
		end else begin
			emit = (query_q.cur != '0) && fin.claimed;
		end
	end

	// A result moves into the output register once that register is free.
	assign load_out = (state_q == ST_DONE) && emit && (!out_valid_q || m_axis_tready);

	// Query loading.
	always_ff @(posedge clk) begin
		if (accept && s_axis_tuser) begin
			query_q.cx2 <= {{(DBL_W-COORD_W){ax[COORD_W-1]}}, ax}
				+ {{(DBL_W-COORD_W){bx[COORD_W-1]}}, bx};
			query_q.cy2 <= {{(DBL_W-COORD_W){ay[COORD_W-1]}}, ay}
				+ {{(DBL_W-COORD_W){by[COORD_W-1]}}, by};
			query_q.cur <= PATH_ID_BITS'(in_cur);
			item_q      <= in_item;
		end
	end

	// Sequencer, configuration register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			run_cnt_q    <= '0;
			area_count_q <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (cfg_we) begin
				area_count_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {16'(emit_path), item_q};
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_axis_tuser) begin
						run_cnt_q <= '0;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (run_cnt_q == RUN_W'(RUN_CYCLES)) begin
						state_q <= ST_DONE;
					end else begin
						run_cnt_q <= run_cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!emit || load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
